// File: src/tstfl_pkg.sv
package tstfl_pkg;

    localparam int SLOT_W = 12;
    localparam int LINK_W = 13;
    localparam int TAG_W  = 32;
    localparam int OPC_W  = 16;
    localparam int PC_W   = 32;

    localparam logic [LINK_W-1:0] LINK_NULL = 13'h1000;
    localparam logic [SLOT_W-1:0] SLOT_MASK = 12'hfff;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_TRIGGER = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_UNBOUND = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [OPC_W-1:0]  opcode;
        logic [PC_W-1:0]   pc;
        logic [SLOT_W-1:0] slot_id;
        logic [TAG_W-1:0]  handler_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  tag_out;
        logic [OPC_W-1:0]  trap_opcode;
        logic [PC_W-1:0]   trap_pc;
        logic              end_slice;
    } out_item_t;

    // classified command as it waits between front and back
    typedef struct packed {
        logic [1:0]        cmd;
        logic              in_range;
        logic [SLOT_W-1:0] slot;
        logic [OPC_W-1:0]  opcode;
        logic [PC_W-1:0]   pc;
        logic [TAG_W-1:0]  tag;
    } task_t;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

// File: src/tstfl_front.sv
module tstfl_front
    import tstfl_pkg::*;
#(
    parameter int SLOT_COUNT = 4096
)
(
    input  in_item_t item,
    output task_t    entry
);

    logic [SLOT_W-1:0] slot;

    always_comb
    begin
        // trigger selects its slot from the low opcode bits
        if (item.cmd == CMD_TRIGGER)
        begin
            slot = item.opcode[SLOT_W-1:0] & SLOT_MASK;
        end
        else
        begin
            slot = item.slot_id;
        end
        entry.cmd      = item.cmd;
        entry.slot     = slot;
        entry.in_range = ({1'b0, slot} < LINK_W'(SLOT_COUNT));
        entry.opcode   = item.opcode;
        entry.pc       = item.pc;
        entry.tag      = item.handler_tag;
    end

endmodule

// File: src/tstfl_queue.sv
module tstfl_queue
    import tstfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output task_t pop_data
);

    task_t      entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/tstfl_back.sv
module tstfl_back
    import tstfl_pkg::*;
#(
    parameter int SLOT_COUNT = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    input  task_t     task_data,
    output logic      task_pop,
    output logic      init_busy,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic [TAG_W-1:0]  tag_mem  [SLOT_COUNT];
    logic [LINK_W-1:0] link_mem [SLOT_COUNT];

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;
    logic [LINK_W-1:0] head_reg, head_next;
    task_t             cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [TAG_W-1:0]  tag_rd_reg;
    logic [LINK_W-1:0] link_rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr;
    logic [TAG_W-1:0]  tag_wdata;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic              can_take;
    logic              list_empty;
    logic              load_out;
    out_item_t         result;

    assign can_take   = !out_valid_reg || out_ready;
    assign list_empty = (head_reg >= LINK_W'(SLOT_COUNT));
    assign init_busy  = (state_reg == BK_INIT);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        task_pop      = 1'b0;
        rd_addr       = task_data.slot[IDX_W-1:0];
        tag_we        = 1'b0;
        tag_waddr     = task_data.slot[IDX_W-1:0];
        tag_wdata     = '0;
        link_we       = 1'b0;
        link_waddr    = task_data.slot[IDX_W-1:0];
        link_wdata    = head_reg;
        load_out      = 1'b0;
        result        = '0;

        unique case (state_reg)
            BK_INIT:
            begin
                // sweep the table: tags unbound, links chained in order
                tag_we     = 1'b1;
                tag_waddr  = init_cnt_reg;
                link_we    = 1'b1;
                link_waddr = init_cnt_reg;
                if (init_cnt_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    link_wdata = LINK_NULL;
                    state_next = BK_IDLE;
                end
                else
                begin
                    link_wdata    = LINK_W'(init_cnt_reg) + LINK_W'(1);
                    init_cnt_next = init_cnt_reg + IDX_W'(1);
                end
            end
            BK_IDLE:
            begin
                if (task_valid && can_take)
                begin
                    task_pop = 1'b1;
                    cur_next = task_data;
                    unique case (task_data.cmd)
                        CMD_ALLOC:
                        begin
                            if (list_empty)
                            begin
                                load_out      = 1'b1;
                                result.status = ST_NO_SLOT;
                            end
                            else
                            begin
                                rd_addr    = head_reg[IDX_W-1:0];
                                state_next = BK_EXEC;
                            end
                        end
                        CMD_FREE:
                        begin
                            // push onto the list head and unbind
                            if (task_data.in_range)
                            begin
                                tag_we    = 1'b1;
                                link_we   = 1'b1;
                                head_next = {1'b0, task_data.slot};
                            end
                            load_out          = 1'b1;
                            result.slot_index = task_data.slot;
                        end
                        CMD_TRIGGER:
                        begin
                            if (task_data.in_range)
                            begin
                                state_next = BK_EXEC;
                            end
                            else
                            begin
                                load_out          = 1'b1;
                                result.status     = ST_UNBOUND;
                                result.slot_index = task_data.slot;
                            end
                        end
                        CMD_READ:
                        begin
                            if (task_data.in_range)
                            begin
                                state_next = BK_EXEC;
                            end
                            else
                            begin
                                load_out          = 1'b1;
                                result.slot_index = task_data.slot;
                            end
                        end
                    endcase
                end
            end
            BK_EXEC:
            begin
                load_out   = 1'b1;
                state_next = BK_IDLE;
                unique case (cur_reg.cmd)
                    CMD_ALLOC:
                    begin
                        // advance the head past the popped slot and bind it
                        head_next         = link_rd_reg;
                        tag_we            = 1'b1;
                        tag_waddr         = head_reg[IDX_W-1:0];
                        tag_wdata         = cur_reg.tag;
                        result.slot_index = head_reg[SLOT_W-1:0];
                        result.tag_out    = cur_reg.tag;
                    end
                    CMD_TRIGGER:
                    begin
                        result.slot_index = cur_reg.slot;
                        if (tag_rd_reg != '0)
                        begin
                            result.tag_out     = tag_rd_reg;
                            result.trap_opcode = cur_reg.opcode;
                            result.trap_pc     = cur_reg.pc;
                            result.end_slice   = 1'b1;
                        end
                        else
                        begin
                            result.status = ST_UNBOUND;
                        end
                    end
                    CMD_READ:
                    begin
                        result.slot_index = cur_reg.slot;
                        result.tag_out    = tag_rd_reg;
                    end
                    CMD_FREE:
                    begin
                        result.slot_index = cur_reg.slot;
                    end
                endcase
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_item_next = out_item_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            init_cnt_reg  <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

endmodule

// File: src/trap_slot_table_free_list_unit.sv
// Trap slot table with a linked free-list allocator. Commands (alloc, free,
// trigger, read) enter through a classifying front end and a two-entry queue,
// and are carried out against synchronous slot memories holding the handler
// tags and the free-list links. After reset the block initialises those
// memories (tags unbound, links chained in slot order) and holds in_ready
// low meanwhile. Thereafter a free, an alloc on an empty list and a trigger
// or read on a slot at or beyond SLOT_COUNT are answered from the idle state;
// other allocs, triggers and reads also pass the execute state, which uses
// the registered memory read of the head's link or the slot's tag. One result
// comes back per command, in order, through an output register.
module trap_slot_table_free_list_unit
    import tstfl_pkg::*;
#(
    parameter int SLOT_COUNT = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    task_t front_entry;
    task_t queue_entry;
    logic  queue_full;
    logic  queue_valid;
    logic  queue_pop;
    logic  init_busy;

    assign in_ready = !queue_full && !init_busy;

    tstfl_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .item  (in_item),
        .entry (front_entry)
    );

    tstfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (front_entry),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_entry)
    );

    tstfl_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (queue_valid),
        .task_data  (queue_entry),
        .task_pop   (queue_pop),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

// File: verif/testbench.sv
module testbench;
    import tstfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = 4096;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    trap_slot_table_free_list_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // shadow of the slot table
    logic [LINK_W-1:0] next_free [SLOT_COUNT];
    logic [TAG_W-1:0]  bound_tag [SLOT_COUNT];
    logic [LINK_W-1:0] list_head;

    in_item_t  cmd_q[$];
    out_item_t slot_results_q[$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int result_count = 0;
    int trap_count   = 0;
    int alinex_count = 0;
    int empty_count  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_item_t slot_table_predict(input in_item_t it);
        out_item_t         r;
        logic [SLOT_W-1:0] s;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_ALLOC:
            begin
                if (int'(list_head) >= SLOT_COUNT)
                    r.status = ST_NO_SLOT;
                else
                begin
                    s = list_head[SLOT_W-1:0];
                    list_head = next_free[s];
                    bound_tag[s] = it.handler_tag;
                    r.slot_index = s;
                    r.tag_out = it.handler_tag;
                end
            end
            CMD_FREE:
            begin
                if (int'(it.slot_id) < SLOT_COUNT)
                begin
                    next_free[it.slot_id] = list_head;
                    bound_tag[it.slot_id] = '0;
                    list_head = {1'b0, it.slot_id};
                end
                r.slot_index = it.slot_id;
            end
            CMD_TRIGGER:
            begin
                s = it.opcode[SLOT_W-1:0] & SLOT_MASK;
                r.slot_index = s;
                if (int'(s) < SLOT_COUNT && bound_tag[s] != '0)
                begin
                    r.tag_out     = bound_tag[s];
                    r.trap_opcode = it.opcode;
                    r.trap_pc     = it.pc;
                    r.end_slice   = 1'b1;
                end
                else
                    r.status = ST_UNBOUND;
            end
            default:
            begin
                r.slot_index = it.slot_id;
                if (int'(it.slot_id) < SLOT_COUNT)
                    r.tag_out = bound_tag[it.slot_id];
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t make_cmd(input logic [1:0] cmd, input logic [OPC_W-1:0] opc,
                                          input logic [PC_W-1:0] pcv,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [TAG_W-1:0] tag);
        in_item_t it;
        it.cmd         = cmd;
        it.opcode      = opc;
        it.pc          = pcv;
        it.slot_id     = slot;
        it.handler_tag = tag;
        return it;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    // mostly addresses a small window of hot slots so that frees, reads and
    // triggers land on recently allocated entries
    task automatic push_mixed(input int n);
        in_item_t          it;
        logic [SLOT_W-1:0] slot;
        int                sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 6)
                slot = SLOT_W'($urandom_range(0, 31));
            else
                slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
            it = make_cmd(CMD_READ, OPC_W'($urandom), $urandom, slot, pick_tag());
            if (sel < 30)
                it.cmd = CMD_ALLOC;
            else if (sel < 55)
                it.cmd = CMD_FREE;
            else if (sel < 80)
            begin
                it.cmd = CMD_TRIGGER;
                if ($urandom_range(0, 3) != 0)
                    it.opcode = {4'hA, slot};
            end
            cmd_q.push_back(it);
        end
    endtask

    task automatic wait_until_quiet();
        while (cmd_q.size() != 0 || in_valid || slot_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_result(input out_item_t want, input out_item_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected 0x%03h, got 0x%03h", want.slot_index, got.slot_index);
            fail_count++;
        end
        if (got.tag_out !== want.tag_out)
        begin
            $error("tag_out: expected 0x%08h, got 0x%08h", want.tag_out, got.tag_out);
            fail_count++;
        end
        if (got.trap_opcode !== want.trap_opcode)
        begin
            $error("trap_opcode: expected 0x%04h, got 0x%04h", want.trap_opcode,
                   got.trap_opcode);
            fail_count++;
        end
        if (got.trap_pc !== want.trap_pc)
        begin
            $error("trap_pc: expected 0x%08h, got 0x%08h", want.trap_pc, got.trap_pc);
            fail_count++;
        end
        if (got.end_slice !== want.end_slice)
        begin
            $error("end_slice: expected %0d, got %0d", want.end_slice, got.end_slice);
            fail_count++;
        end
    endtask

    // driver: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                slot_results_q.push_back(slot_table_predict(in_item));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() != 0)
                begin
                    in_item  <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: receiver alternates between free flow, light and heavy stalls
    int stall_mode = 0;
    int stall_span = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (slot_results_q.size() == 0)
                begin
                    $error("unexpected result: slot_index 0x%03h status %0d",
                           out_item.slot_index, out_item.status);
                    fail_count++;
                end
                else
                begin
                    out_item_t want;
                    want = slot_results_q.pop_front();
                    compare_result(want, out_item);
                    result_count++;
                    if (want.end_slice)
                        trap_count++;
                    if (want.status == ST_UNBOUND)
                        alinex_count++;
                    if (want.status == ST_NO_SLOT)
                        empty_count++;
                end
            end
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_span = $urandom_range(10, 60);
            end
            stall_span--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 2) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            next_free[i] = (i + 1 < SLOT_COUNT) ? LINK_W'(i + 1) : LINK_NULL;
            bound_tag[i] = '0;
        end
        list_head = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // bind, unbind and trap on a handful of slots
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'hA000, 32'h0,        12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'hFFFFFFFF));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'hA000, 32'hFFFFFFFF, 12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'hA001, 32'h00001000, 12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'h001, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h00000001));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'hF002, 32'h0,        12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'hFFFF, 32'h12345678, 12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'hFFF, 32'h0));
        cmd_q.push_back(make_cmd(CMD_FREE,    16'h0000, 32'h0,        12'h002, 32'h0));
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'h002, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'hDEADBEEF));
        wait_until_quiet();

        // free of the last slot, then a double free that leaves a loop
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'hFFF, 32'h0));
        cmd_q.push_back(make_cmd(CMD_TRIGGER, 16'h0FFF, 32'h80000000, 12'h000, 32'h0));
        cmd_q.push_back(make_cmd(CMD_FREE,    16'h0000, 32'h0,        12'hFFF, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h00000005));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h00000006));
        cmd_q.push_back(make_cmd(CMD_FREE,    16'h0000, 32'h0,        12'h007, 32'h0));
        cmd_q.push_back(make_cmd(CMD_FREE,    16'h0000, 32'h0,        12'h007, 32'h0));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h80000000));
        cmd_q.push_back(make_cmd(CMD_ALLOC,   16'h0000, 32'h0,        12'h000, 32'h7FFFFFFF));
        cmd_q.push_back(make_cmd(CMD_READ,    16'h0000, 32'h0,        12'h007, 32'h0));
        wait_until_quiet();

        push_mixed(240);
        wait_until_quiet();
        push_mixed(240);
        wait_until_quiet();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d cycles", result_count, cycle_count);
        $display("traps taken %0d, A-line exceptions %0d, allocs on an empty list %0d",
                 trap_count, alinex_count, empty_count);
        if (fail_count == 0 && slot_results_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
